// ===== sv/mcpf_pkg.sv =====
// ----------------------------------------------------------------------------
// Multi-channel pipe FIFO package
// Command and status codes and the fixed field widths of the pipe FIFO.
// ----------------------------------------------------------------------------
package mcpf_pkg;

    localparam int FUNC_W   = 3;
    localparam int ID_W     = 4;
    localparam int DATA_W   = 8;
    localparam int LEN_W    = 5;
    localparam int STATUS_W = 3;
    localparam int REF_W    = 8;

    localparam logic [REF_W-1:0] REF_MAX = '1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC       = 3'd0,
        FUNC_ADD_READER  = 3'd1,
        FUNC_ADD_WRITER  = 3'd2,
        FUNC_CLOSE_READ  = 3'd3,
        FUNC_CLOSE_WRITE = 3'd4,
        FUNC_FREE        = 3'd5,
        FUNC_WRITE_BYTE  = 3'd6,
        FUNC_READ        = 3'd7
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 3'd0,
        STATUS_INVALID = 3'd1,
        STATUS_NO_SLOT = 3'd2,
        STATUS_BLOCK   = 3'd3,
        STATUS_EOF     = 3'd4,
        STATUS_BROKEN  = 3'd5,
        STATUS_BUSY    = 3'd6
    } status_t;

endpackage

// ===== sv/mcpf_ram.sv =====
// ----------------------------------------------------------------------------
// Pipe FIFO memory
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read that holds its value until the next read enable.
// ----------------------------------------------------------------------------
module mcpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/multi_channel_pipe_fifo_top.sv =====
// An invalid-slot command or an alloc answers from its own state (an alloc scans
// the slots in groups of up to 16); other commands read the descriptor first, and
// a read then fetches its first byte and returns one byte per cycle unless the
// output stalls. The input takes no new command until the current command has
// issued its last result.
// Reset: synchronous, active low; clears the slot-in-use flags.
// ----------------------------------------------------------------------------
// Multi-channel pipe FIFO
// Table of byte pipes kept in a descriptor RAM and a shared byte store RAM.
// ----------------------------------------------------------------------------
module multi_channel_pipe_fifo_top #(
    parameter int PIPE_SLOTS     = 16,
    parameter int BUFFER_BYTES   = 512,
    parameter int MAX_READ_BURST = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [mcpf_pkg::FUNC_W-1:0]     s_func,
    input  logic [mcpf_pkg::ID_W-1:0]       s_pipe_id,
    input  logic [mcpf_pkg::DATA_W-1:0]     s_write_data,
    input  logic [mcpf_pkg::LEN_W-1:0]      s_request_length,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [mcpf_pkg::STATUS_W-1:0]   m_status,
    output logic [mcpf_pkg::ID_W-1:0]       m_slot_granted,
    output logic [mcpf_pkg::DATA_W-1:0]     m_read_data,
    output logic                            m_last
);

    import mcpf_pkg::*;

    localparam int SW    = (PIPE_SLOTS > 1) ? $clog2(PIPE_SLOTS) : 1;
    localparam int PW    = $clog2(BUFFER_BYTES);
    localparam int FW    = $clog2(BUFFER_BYTES + 1);
    localparam int CW    = $clog2(MAX_READ_BURST + 1);
    localparam int DW    = 2 * REF_W + 2 * PW + FW;
    localparam int DEPTH = PIPE_SLOTS * BUFFER_BYTES;
    localparam int AW    = $clog2(DEPTH);
    localparam int DDEP  = (PIPE_SLOTS > 1) ? PIPE_SLOTS : 2;
    localparam int GW    = (PIPE_SLOTS < 16) ? PIPE_SLOTS : 16;
    localparam int NG    = (PIPE_SLOTS + GW - 1) / GW;
    localparam int GRW   = (NG > 1) ? $clog2(NG) : 1;
    localparam int GIW   = (GW > 1) ? $clog2(GW) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_INVALID,
        S_DESC,
        S_EXEC,
        S_RD_EMIT
    } state_t;

    state_t                 state_reg, state_next;
    func_t                  func_reg, func_next;
    logic [SW-1:0]          slot_reg, slot_next;
    logic [DATA_W-1:0]      wdata_reg, wdata_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [GRW-1:0]         grp_reg, grp_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [PW-1:0]          head_reg, head_next;
    logic [FW-1:0]          fill_reg, fill_next;
    logic [PIPE_SLOTS-1:0]  used_reg, used_next;

    logic                   m_valid_reg, m_valid_next;
    status_t                m_status_reg, m_status_next;
    logic [ID_W-1:0]        m_slot_reg, m_slot_next;
    logic [DATA_W-1:0]      m_data_reg, m_data_next;
    logic                   m_last_reg, m_last_next;

    // Descriptor and byte store RAM ports.
    logic                   desc_we, desc_re;
    logic [SW-1:0]          desc_waddr, desc_raddr;
    logic [DW-1:0]          desc_wdata, desc_rdata;
    logic                   byte_we, byte_re;
    logic [AW-1:0]          byte_waddr, byte_raddr;
    logic [DATA_W-1:0]      byte_rdata;

    // Fields of the descriptor read back for the current command.
    logic [REF_W-1:0]       d_rrefs, d_wrefs;
    logic [PW-1:0]          d_head, d_tail;
    logic [FW-1:0]          d_fill;

    logic                   can_load;
    logic                   emit;
    status_t                emit_status;
    logic [ID_W-1:0]        emit_slot;
    logic [DATA_W-1:0]      emit_data;
    logic                   emit_last;

    logic [SW-1:0]          slot_in;
    logic                   pipe_ok;
    logic [NG*GW-1:0]       used_pad;
    logic [GW-1:0]          free_bits;
    logic [GIW-1:0]         free_idx;
    logic [SW-1:0]          alloc_slot;
    logic [CW-1:0]          burst_len;
    logic [CW-1:0]          take_len;
    logic [REF_W-1:0]       rrefs_new, wrefs_new;

    function automatic logic [AW-1:0] byte_addr(input logic [SW-1:0] slot,
                                                input logic [PW-1:0] pos);
        byte_addr = AW'(AW'(slot) * AW'(BUFFER_BYTES) + AW'(pos));
    endfunction

    function automatic logic [PW-1:0] next_pos(input logic [PW-1:0] pos);
        next_pos = (pos == PW'(BUFFER_BYTES - 1)) ? '0 : pos + PW'(1);
    endfunction

    assign {d_rrefs, d_wrefs, d_head, d_tail, d_fill} = desc_rdata;

    assign slot_in  = SW'(s_pipe_id);
    assign pipe_ok  = (32'(s_pipe_id) < PIPE_SLOTS) && used_reg[slot_in];
    assign can_load = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);

    // Lowest free slot within the group of slots being scanned this cycle.
    always_comb begin
        used_pad = '1;
        used_pad[PIPE_SLOTS-1:0] = used_reg;
        free_bits = ~used_pad[grp_reg * GW +: GW];
        free_idx = '0;
        for (int i = GW - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                free_idx = GIW'(i);
            end
        end
        alloc_slot = SW'(32'(grp_reg) * GW + 32'(free_idx));
    end

    // Bytes taken by a read: the request clamped to the burst limit and fill.
    always_comb begin
        burst_len = (len_reg > MAX_READ_BURST) ? CW'(MAX_READ_BURST) : CW'(len_reg);
        take_len  = (d_fill < burst_len) ? CW'(d_fill) : burst_len;
    end

    always_comb begin
        rrefs_new = d_rrefs;
        wrefs_new = d_wrefs;
        case (func_reg)
            FUNC_ADD_READER: begin
                if (d_rrefs != REF_MAX) rrefs_new = d_rrefs + REF_W'(1);
            end
            FUNC_ADD_WRITER: begin
                if (d_wrefs != REF_MAX) wrefs_new = d_wrefs + REF_W'(1);
            end
            FUNC_CLOSE_READ: begin
                if (d_rrefs != '0) rrefs_new = d_rrefs - REF_W'(1);
            end
            FUNC_CLOSE_WRITE: begin
                if (d_wrefs != '0) wrefs_new = d_wrefs - REF_W'(1);
            end
            default: begin
                rrefs_new = d_rrefs;
                wrefs_new = d_wrefs;
            end
        endcase
    end

    always_comb begin
        state_next  = state_reg;
        func_next   = func_reg;
        slot_next   = slot_reg;
        wdata_next  = wdata_reg;
        len_next    = len_reg;
        grp_next    = grp_reg;
        count_next  = count_reg;
        head_next   = head_reg;
        fill_next   = fill_reg;
        used_next   = used_reg;

        desc_we     = 1'b0;
        desc_waddr  = slot_reg;
        desc_wdata  = {rrefs_new, wrefs_new, d_head, d_tail, d_fill};
        desc_re     = 1'b0;
        desc_raddr  = slot_in;
        byte_we     = 1'b0;
        byte_waddr  = byte_addr(slot_reg, d_tail);
        byte_re     = 1'b0;
        byte_raddr  = byte_addr(slot_reg, head_reg);

        emit        = 1'b0;
        emit_status = STATUS_OK;
        emit_slot   = '0;
        emit_data   = '0;
        emit_last   = 1'b1;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    func_next  = func_t'(s_func);
                    slot_next  = slot_in;
                    wdata_next = s_write_data;
                    len_next   = s_request_length;
                    grp_next   = '0;
                    if (func_t'(s_func) == FUNC_ALLOC) begin
                        state_next = S_ALLOC;
                    end else if (!pipe_ok) begin
                        state_next = S_INVALID;
                    end else begin
                        desc_re    = 1'b1;
                        state_next = S_DESC;
                    end
                end
            end
            S_ALLOC: begin
                if (can_load) begin
                    if (free_bits != '0) begin
                        used_next[alloc_slot] = 1'b1;
                        desc_we     = 1'b1;
                        desc_waddr  = alloc_slot;
                        desc_wdata  = '0;
                        emit        = 1'b1;
                        emit_slot   = ID_W'(alloc_slot);
                        state_next  = S_IDLE;
                    end else if (grp_reg == GRW'(NG - 1)) begin
                        emit        = 1'b1;
                        emit_status = STATUS_NO_SLOT;
                        state_next  = S_IDLE;
                    end else begin
                        grp_next = grp_reg + GRW'(1);
                    end
                end
            end
            S_INVALID: begin
                if (can_load) begin
                    emit        = 1'b1;
                    emit_status = STATUS_INVALID;
                    state_next  = S_IDLE;
                end
            end
            S_DESC: begin
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (can_load) begin
                    state_next = S_IDLE;
                    emit       = 1'b1;
                    case (func_reg)
                        FUNC_ADD_READER, FUNC_ADD_WRITER: begin
                            desc_we = 1'b1;
                        end
                        FUNC_CLOSE_READ, FUNC_CLOSE_WRITE: begin
                            desc_we = 1'b1;
                            // Both ends closed: the slot goes back to the free pool.
                            if (rrefs_new == '0 && wrefs_new == '0) begin
                                used_next[slot_reg] = 1'b0;
                            end
                        end
                        FUNC_FREE: begin
                            if (d_rrefs != '0 || d_wrefs != '0) begin
                                emit_status = STATUS_BUSY;
                            end else begin
                                used_next[slot_reg] = 1'b0;
                            end
                        end
                        FUNC_WRITE_BYTE: begin
                            if (d_fill == FW'(BUFFER_BYTES)) begin
                                emit_status = (d_rrefs == '0) ? STATUS_BROKEN
                                                              : STATUS_BLOCK;
                            end else begin
                                byte_we    = 1'b1;
                                desc_we    = 1'b1;
                                desc_wdata = {d_rrefs, d_wrefs, d_head,
                                              next_pos(d_tail), d_fill + FW'(1)};
                            end
                        end
                        FUNC_READ: begin
                            if (len_reg == '0) begin
                                emit_status = STATUS_INVALID;
                            end else if (d_fill == '0) begin
                                emit_status = (d_wrefs == '0) ? STATUS_EOF
                                                              : STATUS_BLOCK;
                            end else begin
                                // No result yet: the first byte is fetched here.
                                emit       = 1'b0;
                                byte_re    = 1'b1;
                                byte_raddr = byte_addr(slot_reg, d_head);
                                head_next  = next_pos(d_head);
                                count_next = take_len - CW'(1);
                                fill_next  = d_fill - FW'(take_len);
                                state_next = S_RD_EMIT;
                            end
                        end
                        default: begin
                            emit_status = STATUS_INVALID;
                        end
                    endcase
                end
            end
            S_RD_EMIT: begin
                if (can_load) begin
                    emit      = 1'b1;
                    emit_data = byte_rdata;
                    emit_last = (count_reg == '0);
                    if (count_reg == '0) begin
                        desc_we    = 1'b1;
                        desc_wdata = {d_rrefs, d_wrefs, head_reg, d_tail, fill_reg};
                        state_next = S_IDLE;
                    end else begin
                        // The next fetch overlaps the hand-off of this byte.
                        byte_re    = 1'b1;
                        head_next  = next_pos(head_reg);
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_slot_next   = m_slot_reg;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;
        if (emit) begin
            m_valid_next  = 1'b1;
            m_status_next = emit_status;
            m_slot_next   = emit_slot;
            m_data_next   = emit_data;
            m_last_next   = emit_last;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
        end
        func_reg      <= func_next;
        slot_reg      <= slot_next;
        wdata_reg     <= wdata_next;
        len_reg       <= len_next;
        grp_reg       <= grp_next;
        count_reg     <= count_next;
        head_reg      <= head_next;
        fill_reg      <= fill_next;
        m_status_reg  <= m_status_next;
        m_slot_reg    <= m_slot_next;
        m_data_reg    <= m_data_next;
        m_last_reg    <= m_last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_slot_granted = m_slot_reg;
    assign m_read_data    = m_data_reg;
    assign m_last         = m_last_reg;

    mcpf_ram #(
        .WIDTH (DW),
        .DEPTH (DDEP)
    ) u_desc_ram (
        .aclk  (aclk),
        .we    (desc_we),
        .waddr (($clog2(DDEP))'(desc_waddr)),
        .wdata (desc_wdata),
        .re    (desc_re),
        .raddr (($clog2(DDEP))'(desc_raddr)),
        .rdata (desc_rdata)
    );

    mcpf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_byte_ram (
        .aclk  (aclk),
        .we    (byte_we),
        .waddr (byte_waddr),
        .wdata (wdata_reg),
        .re    (byte_re),
        .raddr (byte_raddr),
        .rdata (byte_rdata)
    );

endmodule

// ===== sv/mcpf_checker.sv =====
// ----------------------------------------------------------------------------
// Pipe FIFO port checker
// Watches the ports of the pipe FIFO top level over time.
// ----------------------------------------------------------------------------
module mcpf_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [mcpf_pkg::STATUS_W-1:0]   m_status,
    input  logic [mcpf_pkg::ID_W-1:0]       m_slot_granted,
    input  logic [mcpf_pkg::DATA_W-1:0]     m_read_data,
    input  logic                            m_last
);

    import mcpf_pkg::*;

    // Every failing outcome is a single result and so closes its command.
    a_error_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STATUS_OK |-> m_last)
        else $error("error status without last mark");

    // Only successful results carry a slot or a data byte.
    a_error_payload_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STATUS_OK |-> m_slot_granted == '0 && m_read_data == '0)
        else $error("error result with non-zero payload");

    // One command at a time: the input closes after each transaction.
    a_one_command: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted a second command back to back");

    // A stalled result keeps its status, last mark and data byte.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_last)
                                && $stable(m_read_data))
        else $error("stalled result changed");

endmodule

bind multi_channel_pipe_fifo_top mcpf_checker u_mcpf_checker (.*);
